// ===== design/brf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_pkg
// Shared widths, operation codes and defaults for the circular byte FIFO.
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int DEFAULT_CAPACITY = 64;
  localparam int MAX_CAPACITY     = 64;

  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 7;
  localparam int MODE_W  = 2;

  typedef logic [MODE_W-1:0]  mode_t;
  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam mode_t MODE_WRITE = 2'd0;
  localparam mode_t MODE_READ  = 2'd1;
  localparam mode_t MODE_PEEK  = 2'd2;
  localparam mode_t MODE_DROP  = 2'd3;

endpackage

// ===== design/byte_ring_fifo_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_top
// Circular byte FIFO with write, read, peek and drop operations.
// ----------------------------------------------------------------------------
// Write and drop: one result, registered the cycle after the input transfer.
// Read and peek: one result per byte, the first registered the cycle after
// the transfer, then one per cycle while results are taken, paced by the
// single synchronous read port of the store. A read or peek blocks new input
// until its last byte is fetched. Reset empties the FIFO (pointers zero, empty
// flag set); the byte store holds no reset value and needs no clearing pass.
module byte_ring_fifo_top
  import brf_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic          clk,
  input  logic          rst,

  input  logic          in_valid,
  output logic          in_ready,
  input  mode_t         mode,
  input  byte_t         write_byte,
  input  count_t        request_count,

  output logic          out_valid,
  input  logic          out_ready,
  output byte_t         out_byte,
  output logic          byte_valid,
  output logic          last,
  output count_t        done_count,
  output count_t        fill_level,
  output count_t        free_space
);

  localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam count_t       CAP_C    = COUNT_W'(CAPACITY);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CAPACITY - 1);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_STREAM = 1'b1;

  // control state
  logic             state;
  logic [PTR_W-1:0] read_pointer;
  logic [PTR_W-1:0] write_pointer;
  logic             empty_flag;

  // streaming state
  logic [PTR_W-1:0] addr;
  count_t           remaining;

  // byte store
  byte_t            byte_store [CAPACITY];
  byte_t            rd_data;
  logic             rd_en;
  logic [PTR_W-1:0] rd_addr;
  logic             wr_en;

  // result register
  logic             res_byte_valid;
  logic             res_last;
  count_t           res_done;
  count_t           res_fill;

  // next values
  logic             state_next;
  logic [PTR_W-1:0] read_pointer_next;
  logic [PTR_W-1:0] write_pointer_next;
  logic             empty_flag_next;
  logic [PTR_W-1:0] addr_next;
  count_t           remaining_next;

  logic             out_free;
  logic             in_fire;
  logic             stream_step;
  count_t           fill_now;
  logic             full;
  count_t           n_clamp;
  count_t           rp_sum;
  logic [PTR_W-1:0] rp_adv;
  logic [PTR_W-1:0] wp_inc;
  logic [PTR_W-1:0] rp_inc;
  logic             is_fetch_op;
  logic             load_res;
  logic             load_byte_valid;
  logic             load_last;
  count_t           load_done;
  count_t           load_fill;

  assign out_free    = !out_valid || out_ready;
  assign in_ready    = (state == ST_IDLE) && out_free;
  assign in_fire     = in_valid && in_ready;
  assign stream_step = (state == ST_STREAM) && out_free;

  always_comb begin
    if (write_pointer > read_pointer) begin
      fill_now = COUNT_W'(write_pointer) - COUNT_W'(read_pointer);
    end else if (write_pointer < read_pointer) begin
      fill_now = CAP_C - COUNT_W'(read_pointer) + COUNT_W'(write_pointer);
    end else begin
      fill_now = empty_flag ? '0 : CAP_C;
    end
  end

  assign full    = (fill_now == CAP_C);
  assign n_clamp = (request_count > fill_now) ? fill_now : request_count;
  assign rp_sum  = COUNT_W'(read_pointer) + n_clamp;
  assign rp_adv  = (rp_sum >= CAP_C) ? PTR_W'(rp_sum - CAP_C) : rp_sum[PTR_W-1:0];
  assign wp_inc  = (write_pointer == LAST_PTR) ? '0 : write_pointer + 1'b1;
  assign rp_inc  = (read_pointer == LAST_PTR) ? '0 : read_pointer + 1'b1;

  assign is_fetch_op = ((mode == MODE_READ) || (mode == MODE_PEEK)) && (n_clamp != '0);

  always_comb begin
    state_next         = state;
    read_pointer_next  = read_pointer;
    write_pointer_next = write_pointer;
    empty_flag_next    = empty_flag;
    addr_next          = addr;
    remaining_next     = remaining;
    wr_en              = 1'b0;
    rd_en              = 1'b0;
    rd_addr            = read_pointer;
    load_res           = 1'b0;
    load_byte_valid    = 1'b0;
    load_last          = 1'b1;
    load_done          = res_done;
    load_fill          = res_fill;

    if (in_fire) begin
      load_res = 1'b1;
      case (mode)
        MODE_WRITE: begin
          if (!full) begin
            wr_en              = 1'b1;
            write_pointer_next = wp_inc;
            empty_flag_next    = 1'b0;
            load_done          = COUNT_W'(1);
            load_fill          = fill_now + 1'b1;
          end else begin
            load_done = '0;
            load_fill = fill_now;
          end
        end
        MODE_DROP: begin
          // a zero drop on a full FIFO still sets the empty flag
          read_pointer_next = rp_adv;
          load_done         = n_clamp;
          if (rp_adv == write_pointer) begin
            empty_flag_next = 1'b1;
            load_fill       = '0;
          end else begin
            load_fill = fill_now - n_clamp;
          end
        end
        default: begin
          load_done = n_clamp;
          load_fill = fill_now;
          if (is_fetch_op) begin
            // fetch the first byte now, stream the rest
            rd_en           = 1'b1;
            rd_addr         = read_pointer;
            load_byte_valid = 1'b1;
            load_last       = (n_clamp == COUNT_W'(1));
            addr_next       = rp_inc;
            remaining_next  = n_clamp - 1'b1;
            if (n_clamp != COUNT_W'(1)) begin
              state_next = ST_STREAM;
            end
            if (mode == MODE_READ) begin
              read_pointer_next = rp_adv;
              load_fill         = fill_now - n_clamp;
              if (rp_adv == write_pointer) begin
                empty_flag_next = 1'b1;
              end
            end
          end
        end
      endcase
    end else if (stream_step) begin
      load_res        = 1'b1;
      rd_en           = 1'b1;
      rd_addr         = addr;
      load_byte_valid = 1'b1;
      load_last       = (remaining == COUNT_W'(1));
      addr_next       = (addr == LAST_PTR) ? '0 : addr + 1'b1;
      remaining_next  = remaining - 1'b1;
      if (remaining == COUNT_W'(1)) begin
        state_next = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      read_pointer  <= '0;
      write_pointer <= '0;
      empty_flag    <= 1'b1;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      read_pointer  <= read_pointer_next;
      write_pointer <= write_pointer_next;
      empty_flag    <= empty_flag_next;
      if (load_res) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr      <= addr_next;
    remaining <= remaining_next;
    if (load_res) begin
      res_byte_valid <= load_byte_valid;
      res_last       <= load_last;
      res_done       <= load_done;
      res_fill       <= load_fill;
    end
  end

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      byte_store[write_pointer] <= write_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= byte_store[rd_addr];
    end
  end

  assign out_byte   = res_byte_valid ? rd_data : '0;
  assign byte_valid = res_byte_valid;
  assign last       = res_last;
  assign done_count = res_done;
  assign fill_level = res_fill;
  assign free_space = CAP_C - res_fill;

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_now <= CAP_C)
    else $error("fill level above capacity");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    empty_flag |-> (read_pointer == write_pointer))
    else $error("empty flag set with unequal pointers");

  a_stream_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STREAM) |-> (remaining != '0))
    else $error("streaming with nothing left");

  a_stream_end: assert property (@(posedge clk) disable iff (rst)
    (stream_step && remaining == COUNT_W'(1)) |=>
      (state == ST_IDLE && out_valid && res_last && res_byte_valid))
    else $error("stream did not end on its last byte");

  a_write_nonempty: assert property (@(posedge clk) disable iff (rst)
    (in_fire && mode == MODE_WRITE && !full) |=> (!empty_flag && fill_level != '0))
    else $error("accepted write left FIFO empty");

endmodule

// ===== bench/tb_byte_ring_fifo_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_ring_fifo_top
// Self-checking bench for the circular byte FIFO. A shadow FIFO kept in a
// class predicts every result of each write, read, peek and drop transfer.
// The bench covers empty and full corners, clamped requests, pointer wrap,
// random traffic with idle gaps, and a long hold-off on the result side.
// ----------------------------------------------------------------------------
import brf_pkg::*;

typedef struct packed {
  byte_t  out_byte;
  logic   byte_valid;
  logic   last;
  count_t done_count;
  count_t fill_level;
  count_t free_space;
} fifo_result_t;

class byte_ring_mirror;
  byte_t        ring [DEFAULT_CAPACITY];
  int unsigned  head;
  int unsigned  tail;
  bit           is_empty;
  fifo_result_t due_results [$];
  int           mismatches;

  function new();
    head       = 0;
    tail       = 0;
    is_empty   = 1'b1;
    mismatches = 0;
  endfunction

  function int unsigned level();
    if (tail > head) return tail - head;
    if (tail < head) return DEFAULT_CAPACITY - head + tail;
    return is_empty ? 0 : DEFAULT_CAPACITY;
  endfunction

  // Fill and free space are taken after the pointer update.
  function void push_due(byte_t b, bit v, bit l, int unsigned n);
    fifo_result_t r;
    int unsigned  f;
    f            = level();
    r.out_byte   = b;
    r.byte_valid = v;
    r.last       = l;
    r.done_count = count_t'(n);
    r.fill_level = count_t'(f);
    r.free_space = count_t'(DEFAULT_CAPACITY - f);
    due_results.push_back(r);
  endfunction

  function void apply_op(mode_t m, byte_t b, count_t req);
    int unsigned f;
    int unsigned n;
    int unsigned start;
    f = level();
    n = (req > f) ? f : req;
    case (m)
      MODE_WRITE: begin
        if (f < DEFAULT_CAPACITY) begin
          ring[tail] = b;
          tail       = (tail + 1) % DEFAULT_CAPACITY;
          is_empty   = 1'b0;
          push_due(8'h00, 1'b0, 1'b1, 1);
        end else begin
          push_due(8'h00, 1'b0, 1'b1, 0);
        end
      end
      MODE_DROP: begin
        // A zero drop on a full FIFO also sets the empty flag.
        head = (head + n) % DEFAULT_CAPACITY;
        if (head == tail) is_empty = 1'b1;
        push_due(8'h00, 1'b0, 1'b1, n);
      end
      default: begin
        if (n == 0) begin
          push_due(8'h00, 1'b0, 1'b1, 0);
        end else begin
          start = head;
          if (m == MODE_READ) begin
            head = (head + n) % DEFAULT_CAPACITY;
            if (head == tail) is_empty = 1'b1;
          end
          for (int i = 0; i < n; i++)
            push_due(ring[(start + i) % DEFAULT_CAPACITY], 1'b1, (i + 1 == n), n);
        end
      end
    endcase
  endfunction

  function void match_result(fifo_result_t got);
    fifo_result_t want;
    if (due_results.size() == 0) begin
      $error("unexpected result: out_byte %0d last %0d", got.out_byte, got.last);
      mismatches++;
      return;
    end
    want = due_results.pop_front();
    if (got.out_byte !== want.out_byte) begin
      $error("out_byte: expected %0d, got %0d", want.out_byte, got.out_byte);
      mismatches++;
    end
    if (got.byte_valid !== want.byte_valid) begin
      $error("byte_valid: expected %0d, got %0d", want.byte_valid, got.byte_valid);
      mismatches++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      mismatches++;
    end
    if (got.done_count !== want.done_count) begin
      $error("done_count: expected %0d, got %0d", want.done_count, got.done_count);
      mismatches++;
    end
    if (got.fill_level !== want.fill_level) begin
      $error("fill_level: expected %0d, got %0d", want.fill_level, got.fill_level);
      mismatches++;
    end
    if (got.free_space !== want.free_space) begin
      $error("free_space: expected %0d, got %0d", want.free_space, got.free_space);
      mismatches++;
    end
  endfunction
endclass

module tb_byte_ring_fifo_top;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_STALL   = 300;
  localparam int RANDOM_ITEMS = 60;
  localparam int TAIL_CYCLES  = 20;

  logic   clk;
  logic   rst;
  logic   in_valid;
  logic   in_ready;
  mode_t  mode;
  byte_t  write_byte;
  count_t request_count;
  logic   out_valid;
  logic   out_ready;
  byte_t  out_byte;
  logic   byte_valid;
  logic   last;
  count_t done_count;
  count_t fill_level;
  count_t free_space;

  bit calm;
  bit stall_req;
  int cycle_count;

  byte_ring_mirror shadow = new();

  byte_ring_fifo_top #(.CAPACITY(DEFAULT_CAPACITY)) DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .write_byte    (write_byte),
    .request_count (request_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .last          (last),
    .done_count    (done_count),
    .fill_level    (fill_level),
    .free_space    (free_space)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      shadow.match_result(fifo_result_t'{out_byte, byte_valid, last,
                                         done_count, fill_level, free_space});
  end

  // Result side: random stalls, or a long hold-off on request.
  initial begin
    out_ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (stall_req) begin
        out_ready <= 1'b0;
        repeat (LONG_STALL) @(negedge clk);
        stall_req = 1'b0;
      end
      out_ready <= calm || ($urandom_range(99) >= 7);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  // with valid still high, so a back-to-back transfer needs no extra edge.
  task automatic send_op(mode_t m, byte_t b, count_t n);
    if (!calm) begin
      while ($urandom_range(99) < 7) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid      <= 1'b1;
    mode          <= m;
    write_byte    <= b;
    request_count <= n;
    do @(posedge clk); while (!in_ready);
    shadow.apply_op(m, b, n);
    @(negedge clk);
  endtask

  // Hold off the input until every predicted result has arrived.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (shadow.due_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic count_t rand_count();
    return ($urandom_range(9) == 0) ? count_t'($urandom_range(127))
                                    : count_t'($urandom_range(12));
  endfunction

  task automatic run_directed();
    send_op(MODE_READ,  8'h00, 7'd0);
    send_op(MODE_PEEK,  8'h00, 7'd127);
    send_op(MODE_DROP,  8'h00, 7'd64);
    send_op(MODE_WRITE, 8'h00, 7'd0);
    send_op(MODE_WRITE, 8'hFF, 7'd127);
    send_op(MODE_WRITE, 8'h5A, 7'd0);
    send_op(MODE_WRITE, 8'hA5, 7'd0);
    send_op(MODE_WRITE, 8'h01, 7'd0);
    send_op(MODE_PEEK,  8'hFF, 7'd3);
    send_op(MODE_PEEK,  8'h00, 7'd0);
    send_op(MODE_READ,  8'h00, 7'd2);
    send_op(MODE_DROP,  8'h00, 7'd1);
    send_op(MODE_READ,  8'h00, 7'd127);
    send_op(MODE_READ,  8'h00, 7'd1);
    send_op(MODE_WRITE, 8'h80, 7'd0);
    send_op(MODE_WRITE, 8'h7F, 7'd0);
    send_op(MODE_WRITE, 8'h3C, 7'd0);
    send_op(MODE_DROP,  8'h00, 7'd0);
    send_op(MODE_DROP,  8'h00, 7'd127);
    send_op(MODE_PEEK,  8'h00, 7'd1);
  endtask

  task automatic run_pressure();
    // Results are held off, which stalls the writes; the FIFO then fills and refuses the rest.
    stall_req = 1'b1;
    repeat (DEFAULT_CAPACITY + 6)
      send_op(MODE_WRITE, byte_t'($urandom), count_t'($urandom_range(127)));
    wait_drained();
    send_op(MODE_PEEK, byte_t'($urandom), 7'd64);
    send_op(MODE_READ, byte_t'($urandom), 7'd40);
    repeat (40) send_op(MODE_WRITE, byte_t'($urandom), rand_count());
    // Full again with the write pointer wrapped.
    send_op(MODE_PEEK, byte_t'($urandom), 7'd127);
    send_op(MODE_DROP, byte_t'($urandom), 7'd0);
    send_op(MODE_READ, byte_t'($urandom), 7'd5);
    wait_drained();
  endtask

  task automatic run_random();
    int unsigned pick;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      calm = (k >= 15 && k < 40);
      if (k == 45) wait_drained();
      pick = $urandom_range(99);
      if (pick < 4)
        repeat ($urandom_range(4, 12))
          send_op(MODE_WRITE, byte_t'($urandom), rand_count());
      else if (pick < 55)
        send_op(MODE_WRITE, byte_t'($urandom), rand_count());
      else if (pick < 75)
        send_op(MODE_READ, byte_t'($urandom), rand_count());
      else if (pick < 88)
        send_op(MODE_PEEK, byte_t'($urandom), rand_count());
      else
        send_op(MODE_DROP, byte_t'($urandom), rand_count());
    end
    calm = 1'b0;
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    mode          = MODE_WRITE;
    write_byte    = '0;
    request_count = '0;
    calm          = 1'b0;
    stall_req     = 1'b0;
    cycle_count   = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    run_directed();
    run_pressure();
    run_random();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.due_results.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/brf_pkg.sv
design/byte_ring_fifo_top.sv
bench/tb_byte_ring_fifo_top.sv
